// File: hdl/assert_macros.svh
// Assertion macros used by the allocator controller, sfla_ctrl.
// Synthesis builds see empty bodies; no other file is required.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFLA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SFLA_NEVER(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define SFLA_ASSERT(lbl, clk, rstn, prop, msg)
`define SFLA_NEVER(lbl, clk, rstn, prop, msg)
`endif
`endif

// File: hdl/sfla_pkg.sv
// Constants, codes and shared types of the segregated free list allocator.
// Used by every module of the block except sfla_ram; depends on nothing.
`default_nettype none
package sfla_pkg;
	localparam int ARENA_BYTES   = 65536;
	localparam int GRANULE_BYTES = 8;
	localparam int NUM_CLASSES   = 16;
	localparam int GRAN_SHIFT    = $clog2(GRANULE_BYTES);
	localparam int LINK_DEPTH    = ARENA_BYTES / GRANULE_BYTES;
	localparam int SLOT_W        = $clog2(LINK_DEPTH);
	localparam int CLASS_W       = $clog2(NUM_CLASSES);
	localparam int ADDR_W        = 16;
	localparam int BYTES_W       = 16;
	localparam int STATUS_W      = 2;
	localparam int POOL_W        = $clog2(ARENA_BYTES) + 1;
	localparam int EXT_W         = POOL_W + 1;
	localparam int SMALL_LIMIT   = GRANULE_BYTES * NUM_CLASSES;
	localparam int SIZE_W        = $clog2(SMALL_LIMIT) + 1;
	localparam int REFILL_W      = 6;
	localparam int REFILL_RESET  = 20;
	localparam int REFILL_MAX    = 32;
	localparam int TOTAL_W       = SIZE_W + REFILL_W;
	localparam int KCNT_W        = REFILL_W + 1;
	localparam int PASS_W        = 2;
	localparam int PASS_LAST     = 2;
	localparam int HEAP_SHIFT    = 4;
	localparam int S_TDATA_W     = 2 * BYTES_W;
	localparam int M_TDATA_W     = ADDR_W;

	typedef enum logic {OP_ALLOC, OP_FREE} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_ALLOCATED, STAT_FREED, STAT_OVERSIZE, STAT_NOMEM
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_POP, S_CHECK, S_SCAN, S_BORROW, S_LINK
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] idx;
	} entry_t;

	typedef struct packed {
		logic               en;
		logic [CLASS_W-1:0] cls;
		entry_t             entry;
	} head_wr_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
		status_t           status;
	} result_t;
endpackage
`default_nettype wire

// File: hdl/sfla_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; used for the link memory.
`default_nettype none
module sfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// File: hdl/sfla_heads.sv
// Free list head table: one entry per size class, with valid bits cleared on reset.
// Depends on sfla_pkg.
`default_nettype none
module sfla_heads (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [sfla_pkg::CLASS_W-1:0]  rd_cls,
	output sfla_pkg::entry_t                   rd_entry,
	input  wire sfla_pkg::head_wr_t            wr
);
	import sfla_pkg::*;

	logic [NUM_CLASSES-1:0] valid_q;
	logic [SLOT_W-1:0]      idx_q [NUM_CLASSES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.cls] <= wr.entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			idx_q[wr.cls] <= wr.entry.idx;
		end
	end

	assign rd_entry.valid = valid_q[rd_cls];
	assign rd_entry.idx   = idx_q[rd_cls];
endmodule
`default_nettype wire

// File: hdl/sfla_ctrl.sv
// Allocation sequencer: pops, pushes, pool refills and borrowing scans.
// Depends on sfla_pkg, sfla_heads, sfla_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sfla_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          in_op,
	input  wire logic [sfla_pkg::BYTES_W-1:0]  in_bytes,
	input  wire logic [sfla_pkg::ADDR_W-1:0]   in_baddr,
	input  wire logic [sfla_pkg::REFILL_W-1:0] refill,
	input  wire logic                          out_free,
	output sfla_pkg::result_t                  res
);
	import sfla_pkg::*;

	state_t               state_q, state_d;
	op_t                  op_q;
	logic [BYTES_W-1:0]   bytes_q;
	logic [ADDR_W-1:0]    baddr_q;
	logic [CLASS_W-1:0]   cls_q;
	logic [SIZE_W-1:0]    size_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [POOL_W-1:0]    pool_start_q, pool_end_q, btop_q, heap_q, chunk_q;
	logic [PASS_W-1:0]    pass_q;
	logic [CLASS_W-1:0]   scan_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [EXT_W-1:0]     ptr_q;
	logic [KCNT_W-1:0]    k_q;

	logic [BYTES_W-1:0]   bytes_eff;
	logic                 oversize;
	logic [CLASS_W-1:0]   cls_c, left_cls;
	logic [SIZE_W-1:0]    size_c;
	logic [POOL_W-1:0]    left, heap_up, heap_round, borrow_addr, borrow_size;
	logic                 left_ok, grow_ok, last_pass, blk_ok, nxt_ok, scan_last;
	logic [EXT_W-1:0]     grow, btop_grow, ptr_next, ptr_next2, pend_ext;
	logic [SLOT_W-1:0]    ps_slot, ptr_slot, ptr_next_slot;

	logic [CLASS_W-1:0]   head_rd_cls;
	entry_t               head_rd;
	head_wr_t             head_wr_c, head_wr;
	logic                 link_we_c, link_re_c, link_we, link_re;
	logic [SLOT_W-1:0]    link_waddr, link_raddr;
	entry_t               link_wdata, link_rdata;
	logic                 fin_c, go;
	logic [ADDR_W-1:0]    fin_addr;
	status_t              fin_status;

	assign bytes_eff = (bytes_q == '0) ? BYTES_W'(GRANULE_BYTES) : bytes_q;
	assign oversize  = bytes_eff > BYTES_W'(SMALL_LIMIT);
	assign cls_c     = CLASS_W'((bytes_eff - BYTES_W'(1)) >> GRAN_SHIFT);
	assign size_c    = (SIZE_W'(cls_c) + SIZE_W'(1)) << GRAN_SHIFT;

	assign left       = pool_end_q - pool_start_q;
	assign left_ok    = left >= POOL_W'(size_q);
	assign left_cls   = CLASS_W'((left - POOL_W'(1)) >> GRAN_SHIFT);
	// Growth adds twice the refill total plus a sixteenth of the heap rounded up to a granule.
	assign heap_up    = (heap_q >> HEAP_SHIFT) + POOL_W'(GRANULE_BYTES - 1);
	assign heap_round = (heap_up >> GRAN_SHIFT) << GRAN_SHIFT;
	assign grow       = (EXT_W'(total_q) << 1) + EXT_W'(heap_round);
	assign btop_grow  = EXT_W'(btop_q) + grow;
	assign grow_ok    = btop_grow <= EXT_W'(ARENA_BYTES);
	assign last_pass  = pass_q == PASS_W'(PASS_LAST);
	assign scan_last  = scan_q == CLASS_W'(NUM_CLASSES - 1);

	assign borrow_addr = POOL_W'({slot_q, GRAN_SHIFT'(0)});
	assign borrow_size = (POOL_W'(scan_q) + POOL_W'(1)) << GRAN_SHIFT;

	assign pend_ext  = EXT_W'(pool_end_q);
	assign ptr_next  = ptr_q + EXT_W'(size_q);
	assign ptr_next2 = ptr_next + EXT_W'(size_q);
	// Block k at ptr_q exists while it fits in the pool and k is below the refill count.
	assign blk_ok    = (ptr_next <= pend_ext) && (k_q < KCNT_W'(refill));
	assign nxt_ok    = (ptr_next2 <= pend_ext) && ((k_q + KCNT_W'(1)) < KCNT_W'(refill));

	assign ps_slot       = pool_start_q[GRAN_SHIFT+SLOT_W-1:GRAN_SHIFT];
	assign ptr_slot      = ptr_q[GRAN_SHIFT+SLOT_W-1:GRAN_SHIFT];
	assign ptr_next_slot = ptr_next[GRAN_SHIFT+SLOT_W-1:GRAN_SHIFT];

	sfla_heads u_heads (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_cls   (head_rd_cls),
		.rd_entry (head_rd),
		.wr       (head_wr)
	);

	sfla_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (LINK_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	always_comb begin
		head_rd_cls = cls_c;
		head_wr_c   = '0;
		link_we_c   = 1'b0;
		link_waddr  = '0;
		link_wdata  = '0;
		link_re_c   = 1'b0;
		link_raddr  = '0;
		fin_c       = 1'b0;
		fin_addr    = '0;
		fin_status  = STAT_ALLOCATED;
		case (state_q)
			S_EXEC: begin
				if (oversize) begin
					fin_c      = 1'b1;
					fin_status = STAT_OVERSIZE;
				end else if (op_q == OP_FREE) begin
					link_we_c             = 1'b1;
					link_waddr            = baddr_q[GRAN_SHIFT+SLOT_W-1:GRAN_SHIFT];
					link_wdata            = head_rd;
					head_wr_c.en          = 1'b1;
					head_wr_c.cls         = cls_c;
					head_wr_c.entry.valid = 1'b1;
					head_wr_c.entry.idx   = baddr_q[GRAN_SHIFT+SLOT_W-1:GRAN_SHIFT];
					fin_c                 = 1'b1;
					fin_status            = STAT_FREED;
				end else if (head_rd.valid) begin
					link_re_c  = 1'b1;
					link_raddr = head_rd.idx;
				end
			end
			S_POP: begin
				head_wr_c.en    = 1'b1;
				head_wr_c.cls   = cls_q;
				head_wr_c.entry = link_rdata;
				fin_c           = 1'b1;
				fin_addr        = ADDR_W'({slot_q, GRAN_SHIFT'(0)});
			end
			S_CHECK: begin
				if (!left_ok) begin
					// The pool leftover goes to the list of its own size.
					if (left != '0) begin
						head_rd_cls           = left_cls;
						link_we_c             = 1'b1;
						link_waddr            = ps_slot;
						link_wdata            = head_rd;
						head_wr_c.en          = 1'b1;
						head_wr_c.cls         = left_cls;
						head_wr_c.entry.valid = 1'b1;
						head_wr_c.entry.idx   = ps_slot;
					end
					if (grow_ok && last_pass) begin
						fin_c      = 1'b1;
						fin_status = STAT_NOMEM;
					end
				end
			end
			S_SCAN: begin
				head_rd_cls = scan_q;
				if (head_rd.valid) begin
					link_re_c  = 1'b1;
					link_raddr = head_rd.idx;
				end else if (scan_last) begin
					fin_c      = 1'b1;
					fin_status = STAT_NOMEM;
				end
			end
			S_BORROW: begin
				head_wr_c.en    = 1'b1;
				head_wr_c.cls   = scan_q;
				head_wr_c.entry = link_rdata;
				if (last_pass) begin
					fin_c      = 1'b1;
					fin_status = STAT_NOMEM;
				end
			end
			S_LINK: begin
				if (blk_ok) begin
					link_we_c  = 1'b1;
					link_waddr = ptr_slot;
					if (nxt_ok) begin
						link_wdata.valid = 1'b1;
						link_wdata.idx   = ptr_next_slot;
					end
					if (k_q == KCNT_W'(1)) begin
						head_wr_c.en          = 1'b1;
						head_wr_c.cls         = cls_q;
						head_wr_c.entry.valid = 1'b1;
						head_wr_c.entry.idx   = ptr_slot;
					end
				end else begin
					fin_c    = 1'b1;
					fin_addr = chunk_q[ADDR_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// A step that finishes an item waits, with no side effect, until the result slot is free.
	assign go         = !fin_c || out_free;
	assign link_we    = link_we_c && go;
	assign link_re    = link_re_c && go;
	assign head_wr.en    = head_wr_c.en && go;
	assign head_wr.cls   = head_wr_c.cls;
	assign head_wr.entry = head_wr_c.entry;
	assign res.valid  = fin_c && out_free;
	assign res.addr   = fin_addr;
	assign res.status = fin_status;
	assign in_ready   = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		if (go) begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_d = S_EXEC;
					end
				end
				S_EXEC: begin
					if (oversize || op_q == OP_FREE) begin
						state_d = S_IDLE;
					end else if (head_rd.valid) begin
						state_d = S_POP;
					end else begin
						state_d = S_CHECK;
					end
				end
				S_POP: state_d = S_IDLE;
				S_CHECK: begin
					if (left_ok) begin
						state_d = S_LINK;
					end else if (grow_ok) begin
						state_d = last_pass ? S_IDLE : S_CHECK;
					end else begin
						state_d = S_SCAN;
					end
				end
				S_SCAN: begin
					if (head_rd.valid) begin
						state_d = S_BORROW;
					end else if (scan_last) begin
						state_d = S_IDLE;
					end
				end
				S_BORROW: state_d = last_pass ? S_IDLE : S_CHECK;
				S_LINK: begin
					if (!blk_ok) begin
						state_d = S_IDLE;
					end
				end
				default: state_d = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pool_start_q <= '0;
			pool_end_q   <= '0;
			btop_q       <= '0;
			heap_q       <= '0;
		end else begin
			state_q <= state_d;
			if (go) begin
				case (state_q)
					S_CHECK: begin
						if (!left_ok) begin
							if (grow_ok) begin
								pool_start_q <= btop_q;
								pool_end_q   <= POOL_W'(btop_grow);
								btop_q       <= POOL_W'(btop_grow);
								heap_q       <= heap_q + POOL_W'(grow);
							end else begin
								pool_start_q <= pool_end_q;
							end
						end
					end
					S_BORROW: begin
						pool_start_q <= borrow_addr;
						pool_end_q   <= borrow_addr + borrow_size;
					end
					S_LINK: begin
						if (!blk_ok) begin
							pool_start_q <= POOL_W'(ptr_q);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= op_t'(in_op);
						bytes_q <= in_bytes;
						baddr_q <= in_baddr;
					end
				end
				S_EXEC: begin
					cls_q   <= cls_c;
					size_q  <= size_c;
					total_q <= TOTAL_W'(size_c) * TOTAL_W'(refill);
					pass_q  <= '0;
					slot_q  <= head_rd.idx;
				end
				S_CHECK: begin
					if (left_ok) begin
						chunk_q <= pool_start_q;
						ptr_q   <= EXT_W'(pool_start_q) + EXT_W'(size_q);
						k_q     <= KCNT_W'(1);
					end else if (grow_ok) begin
						pass_q <= pass_q + PASS_W'(1);
					end else begin
						scan_q <= cls_q;
					end
				end
				S_SCAN: begin
					if (head_rd.valid) begin
						slot_q <= head_rd.idx;
					end else begin
						scan_q <= scan_q + CLASS_W'(1);
					end
				end
				S_BORROW: pass_q <= pass_q + PASS_W'(1);
				S_LINK: begin
					if (blk_ok) begin
						ptr_q <= ptr_next;
						k_q   <= k_q + KCNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	`SFLA_ASSERT(a_pool_order, clk, arst_n, pool_start_q <= pool_end_q, "pool start passed pool end")
	`SFLA_ASSERT(a_top_in_arena, clk, arst_n, btop_q <= POOL_W'(ARENA_BYTES), "backing top beyond arena")
	`SFLA_NEVER(a_idle_no_write, clk, arst_n, state_q == S_IDLE && (link_we || head_wr.en), "state written while idle")
	`SFLA_ASSERT(a_result_busy, clk, arst_n, res.valid |=> state_q == S_IDLE, "result without returning to idle")
endmodule
`default_nettype wire

// File: hdl/segregated_free_list_allocator_top.sv
// Top level of the segregated free list allocator: stream ports, refill register, result buffer.
// Depends on sfla_pkg and sfla_ctrl.
// One item is in work at a time. Free and oversize use S_IDLE and S_EXEC; a pop adds S_POP.
// Refill adds an S_CHECK per pool check, an S_SCAN per class scanned, an S_BORROW per borrowed
// block and an S_LINK per carved block, all set by the single link memory port.
// Reset clears all lists and the pool and sets refill_count to 20; the link memory is not cleared.
`default_nettype none
module segregated_free_list_allocator_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [sfla_pkg::S_TDATA_W-1:0]  s_tdata,   // size_bytes, block_address
	input  wire logic [0:0]                      s_tuser,   // operation
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [sfla_pkg::M_TDATA_W-1:0]  m_tdata,   // result_address
	output logic      [sfla_pkg::STATUS_W-1:0]   m_tuser,   // status
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [sfla_pkg::REFILL_W-1:0]   cfg_data
);
	import sfla_pkg::*;

	logic [REFILL_W-1:0] refill_q;
	logic                m_tvalid_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [STATUS_W-1:0] status_q;
	logic                out_free;
	result_t             res;

	assign cfg_ready = 1'b1;

	// Out-of-range counts are clamped to 1..32 as they are written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refill_q <= REFILL_W'(REFILL_RESET);
		end else if (cfg_valid) begin
			if (cfg_data == '0) begin
				refill_q <= REFILL_W'(1);
			end else if (cfg_data > REFILL_W'(REFILL_MAX)) begin
				refill_q <= REFILL_W'(REFILL_MAX);
			end else begin
				refill_q <= cfg_data;
			end
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	sfla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser[0]),
		.in_bytes (s_tdata[BYTES_W-1:0]),
		.in_baddr (s_tdata[S_TDATA_W-1:BYTES_W]),
		.refill   (refill_q),
		.out_free (out_free),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			addr_q   <= res.addr;
			status_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = addr_q;
	assign m_tuser  = status_q;
endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the segregated free list allocator top level.
// Depends on sfla_pkg and the allocator RTL; predicts every result in SystemVerilog.
module tb;
	import sfla_pkg::*;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		status_t           status;
	} alloc_result_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [15:0]       size;
	} live_block_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [0:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REFILL_W-1:0]  cfg_data;

	segregated_free_list_allocator_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Shadow allocator state.
	logic              head_v [NUM_CLASSES];
	logic [SLOT_W-1:0] head_i [NUM_CLASSES];
	logic [SLOT_W-1:0] link_i [LINK_DEPTH];
	logic              link_v [LINK_DEPTH];
	longint            pool_lo, pool_hi, top_mark, heap_sum, carve_cnt;
	int                refill_blocks;

	alloc_result_t expected_q[$];
	live_block_t   live_q[$];
	int            fails;
	int            tx_idle_pct, rx_idle_pct;
	int            hold_left;
	int            quiet_cycles;

	function automatic longint gran_round(longint b);
		return ((b + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
	endfunction

	function automatic int class_for(longint b);
		return int'((b + GRANULE_BYTES - 1) / GRANULE_BYTES - 1);
	endfunction

	function automatic void list_push(int cls, longint a);
		logic [SLOT_W-1:0] s;
		s = SLOT_W'((a / GRANULE_BYTES) % LINK_DEPTH);
		if (cls >= NUM_CLASSES) return;
		link_v[s] = head_v[cls];
		link_i[s] = head_i[cls];
		head_v[cls] = 1'b1;
		head_i[cls] = s;
	endfunction

	function automatic bit list_pop(int cls, output longint a);
		logic [SLOT_W-1:0] s;
		a = 0;
		if (cls >= NUM_CLASSES || !head_v[cls]) return 0;
		s = head_i[cls];
		head_v[cls] = link_v[s];
		head_i[cls] = link_i[s];
		a = longint'(s) * GRANULE_BYTES;
		return 1;
	endfunction

	// Carves up to carve_cnt blocks from the pool, regrowing or borrowing as needed.
	function automatic bit carve_pool(longint size, output longint a);
		longint total, left, grow, b;
		bit found;
		a = 0;
		for (int pass = 0; pass < 3; pass++) begin
			total = size * carve_cnt;
			left = pool_hi - pool_lo;
			if (left >= total || left >= size) begin
				if (left < total) begin
					carve_cnt = left / size;
					total = size * carve_cnt;
				end
				a = pool_lo;
				pool_lo += total;
				return 1;
			end
			grow = 2 * total + gran_round(heap_sum >> 4);
			if (left > 0) list_push(class_for(left), pool_lo);
			pool_lo = pool_hi;
			if (top_mark + grow <= ARENA_BYTES) begin
				pool_lo = top_mark;
				top_mark += grow;
				pool_hi = pool_lo + grow;
				heap_sum += grow;
			end else begin
				found = 0;
				for (int i = class_for(size); i < NUM_CLASSES && !found; i++) begin
					if (list_pop(i, b)) begin
						pool_lo = b;
						pool_hi = b + longint'(i + 1) * GRANULE_BYTES;
						found = 1;
					end
				end
				if (!found) return 0;
			end
		end
		return 0;
	endfunction

	function automatic alloc_result_t predict_alloc(op_t op, logic [15:0] size_in,
			logic [15:0] baddr);
		alloc_result_t r;
		longint bytes, a, chunk, sz;
		int cls;
		logic [SLOT_W-1:0] s;
		r.addr = '0;
		bytes = (size_in == 0) ? GRANULE_BYTES : longint'(size_in);
		if (bytes > SMALL_LIMIT) begin
			r.status = STAT_OVERSIZE;
			return r;
		end
		cls = class_for(bytes);
		if (op == OP_FREE) begin
			list_push(cls, (longint'(baddr) / GRANULE_BYTES) * GRANULE_BYTES);
			r.status = STAT_FREED;
			return r;
		end
		if (list_pop(cls, a)) begin
			r.addr = a[ADDR_W-1:0];
			r.status = STAT_ALLOCATED;
			return r;
		end
		sz = gran_round(bytes);
		carve_cnt = refill_blocks;
		if (!carve_pool(sz, chunk)) begin
			r.status = STAT_NOMEM;
			return r;
		end
		if (carve_cnt > 1) begin
			for (longint k = 1; k < carve_cnt; k++) begin
				s = SLOT_W'(((chunk + k * sz) / GRANULE_BYTES) % LINK_DEPTH);
				link_v[s] = (k + 1 < carve_cnt);
				link_i[s] = (k + 1 < carve_cnt) ?
					SLOT_W'(((chunk + (k + 1) * sz) / GRANULE_BYTES) % LINK_DEPTH) : '0;
			end
			head_v[cls] = 1'b1;
			head_i[cls] = SLOT_W'(((chunk + sz) / GRANULE_BYTES) % LINK_DEPTH);
		end
		r.addr = chunk[ADDR_W-1:0];
		r.status = STAT_ALLOCATED;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_item(op_t op, logic [15:0] size_in, logic [15:0] baddr);
		alloc_result_t r;
		live_block_t lb;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {baddr, size_in};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = predict_alloc(op, size_in, baddr);
		expected_q.push_back(r);
		if (op == OP_ALLOC && r.status == STAT_ALLOCATED) begin
			lb.addr = r.addr;
			lb.size = size_in;
			live_q.push_back(lb);
		end
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_refill(logic [REFILL_W-1:0] v);
		int c;
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		c = (v == 0) ? 1 : (v > REFILL_MAX ? REFILL_MAX : int'(v));
		refill_blocks = c;
	endtask

	// Result checker and receiver stall generator.
	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$error("result with no expectation: addr %h status %0d", m_tdata, m_tuser);
				fails++;
			end else begin
				e = expected_q.pop_front();
				if (m_tdata !== e.addr) begin
					$error("result_address expected %h actual %h", e.addr, m_tdata);
					fails++;
				end
				if (m_tuser !== e.status) begin
					$error("status expected %0d actual %0d", e.status, m_tuser);
					fails++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 20000) begin
			$display("segregated_free_list_allocator_top verification failed");
			$finish;
		end
	end

	task automatic test_directed();
		send_item(OP_ALLOC, 16'd0, 16'd0);
		send_item(OP_ALLOC, 16'd1, 16'hFFFF);
		send_item(OP_ALLOC, 16'd8, 16'd0);
		send_item(OP_ALLOC, 16'd9, 16'd0);
		send_item(OP_ALLOC, 16'd128, 16'd0);
		send_item(OP_ALLOC, 16'd129, 16'd0);
		send_item(OP_ALLOC, 16'hFFFF, 16'hFFFF);
		send_item(OP_FREE, 16'hFFFF, 16'h1234);
		send_item(OP_FREE, 16'd129, 16'd8);
		// Unaligned frees are truncated to their granule.
		send_item(OP_FREE, 16'd8, 16'h0013);
		send_item(OP_ALLOC, 16'd8, 16'd0);
		send_item(OP_FREE, 16'd128, 16'hFFFF);
		send_item(OP_ALLOC, 16'd128, 16'd0);
		// A double free simply pushes the block twice.
		send_item(OP_FREE, 16'd64, 16'h0040);
		send_item(OP_FREE, 16'd64, 16'h0040);
		send_item(OP_ALLOC, 16'd64, 16'd0);
		send_item(OP_ALLOC, 16'd64, 16'd0);
		send_item(OP_FREE, 16'd0, 16'd0);
		send_item(OP_ALLOC, 16'd0, 16'd0);
		send_item(OP_ALLOC, 16'd120, 16'd0);
		stop_sending();
		drain();
	endtask

	task automatic random_item();
		live_block_t lb;
		int pick;
		logic [15:0] sz, ad;
		pick = $urandom_range(99);
		if (pick < 50) begin
			if ($urandom_range(9) == 0) sz = 16'($urandom);
			else sz = 16'($urandom_range(128));
			send_item(OP_ALLOC, sz, 16'($urandom));
		end else if (pick < 90 && live_q.size() != 0) begin
			pick = $urandom_range(live_q.size() - 1);
			lb = live_q[pick];
			live_q.delete(pick);
			ad = lb.addr | (($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'd0);
			send_item(OP_FREE, lb.size, ad);
		end else begin
			sz = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(128));
			send_item(OP_FREE, sz, 16'($urandom));
		end
	endtask

	task automatic test_random(int n);
		repeat (n) random_item();
		stop_sending();
		drain();
	endtask

	// The receiver stalls for a long stretch while the sender keeps offering.
	task automatic test_backpressure();
		hold_left = 400;
		repeat (30) random_item();
		stop_sending();
		drain();
	endtask

	initial begin
		fails = 0;
		quiet_cycles = 0;
		hold_left = 0;
		tx_idle_pct = 34;
		rx_idle_pct = 51;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		refill_blocks = REFILL_RESET;
		pool_lo = 0; pool_hi = 0; top_mark = 0; heap_sum = 0; carve_cnt = 0;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			head_v[i] = 1'b0;
			head_i[i] = '0;
		end
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		write_refill(6'd1);
		test_random(90);
		write_refill(6'd32);
		test_random(90);
		tx_idle_pct = 51;
		rx_idle_pct = 34;
		write_refill(6'd0);
		test_random(90);
		write_refill(6'd63);
		test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_refill(6'($urandom_range(2, 31)));
		test_random(90);
		write_refill(6'd20);
		test_random(90);
		write_refill(6'($urandom));
		test_random(60);

		if (fails == 0)
			$display("segregated_free_list_allocator_top verification clean");
		else
			$display("segregated_free_list_allocator_top verification failed");
		$finish;
	end
endmodule

// File: segregated_free_list_allocator_top.f
+incdir+hdl
hdl/sfla_pkg.sv
hdl/sfla_ram.sv
hdl/sfla_heads.sv
hdl/sfla_ctrl.sv
hdl/segregated_free_list_allocator_top.sv
test/tb.sv
